[hdl/stbs_pkg.sv]
// ----------------------------------------------------------------------------
// Sorted table binary search package
// Transaction types and mode codes shared by the search block and its users.
// ----------------------------------------------------------------------------
package stbs_pkg;

	localparam int unsigned POS_W = 11;
	localparam int unsigned IDX_W = 10;
	localparam int unsigned KEY_W = 64;

	localparam logic [1:0] MODE_WRITE      = 2'd0;
	localparam logic [1:0] MODE_EXACT      = 2'd1;
	localparam logic [1:0] MODE_BISECT     = 2'd2;
	localparam logic [1:0] MODE_BISECT_ALT = 2'd3;

	typedef struct packed {
		logic [1:0]              mode;
		logic [IDX_W-1:0]        entry_index;
		logic signed [KEY_W-1:0] key;
	} stbs_in_t;

	typedef struct packed {
		logic [POS_W-1:0] position;
		logic             found;
		logic             empty_table;
	} stbs_out_t;

endpackage

[hdl/sorted_table_binary_search.sv]
// ----------------------------------------------------------------------------
// Sorted table binary search
// Holds a table of signed 64-bit keys and answers exact and bisect queries.
// ----------------------------------------------------------------------------
// A transaction is taken at a rising edge where start is high and busy is low.
// A write transaction (mode 0) stores its key at entry_index and
// gives no result; busy stays low, so the next transaction can follow at once.
// A query gives exactly one result, shown on result for a single cycle while
// result_valid is high. The receiver cannot stall, so it must take the result
// in that cycle. All table reads go through one read port of the key memory
// with registered read data, so each probe is a read state that issues the
// address, then a compare state that compares the returned key and narrows
// the search window. The bisect modes first read the first and last entries
// and then probe unless those already settle the result. The result is
// registered at the end of the last compare state and shown in the cycle
// after it. With an empty table the result comes the cycle after the query.
// Busy is already low in the cycle the result is shown, so the next
// transaction can be taken at the same edge.
// table_size is written through cfg_we/cfg_data
// and must only change while the block is idle; values beyond TABLE_DEPTH are
// treated as TABLE_DEPTH. The key table has no reset: entries must be written
// before any query can reach them.
// ----------------------------------------------------------------------------
module sorted_table_binary_search
	import stbs_pkg::*;
#(
	parameter int unsigned TABLE_DEPTH = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  stbs_in_t         item,
	output logic             result_valid,
	output stbs_out_t        result,
	input  logic             cfg_we,
	input  logic [POS_W-1:0] cfg_data
);

	localparam int unsigned AW = (TABLE_DEPTH > 2) ? $clog2(TABLE_DEPTH) : 1;

	// One-hot sequencer states. Each probe is a read state followed by the
	// compare state that consumes the registered read data.
	typedef enum logic [6:0] {
		S_IDLE      = 7'b0000001,
		S_RD_FIRST  = 7'b0000010,
		S_CMP_FIRST = 7'b0000100,
		S_RD_LAST   = 7'b0001000,
		S_CMP_LAST  = 7'b0010000,
		S_RD_MID    = 7'b0100000,
		S_CMP_MID   = 7'b1000000
	} state_t;

	state_t state_q;

	logic [POS_W-1:0]        table_size_q;
	logic [POS_W-1:0]        eff_size;
	logic [1:0]              mode_q;
	logic signed [KEY_W-1:0] key_q;
	logic [POS_W-1:0]        lo_q;
	logic [POS_W-1:0]        hi_q;

	logic                    result_valid_q;
	logic [POS_W-1:0]        res_pos_q;
	logic                    res_found_q;
	logic                    res_empty_q;

	logic signed [KEY_W-1:0] key_mem [TABLE_DEPTH];
	logic signed [KEY_W-1:0] rd_data_q;
	logic [AW-1:0]           rd_addr;
	logic                    wr_en;

	logic                    accept;
	logic [POS_W:0]          lo_hi_sum;
	logic [POS_W-1:0]        mid;
	logic                    mem_lt_key;
	logic                    key_lt_mem;
	logic                    mem_eq_key;
	logic [POS_W-1:0]        lo_next;
	logic [POS_W-1:0]        hi_next;
	logic                    loop_go;

	assign accept = start && !busy;
	assign busy   = (state_q != S_IDLE);

	// Effective table size saturates at the memory depth.
	assign eff_size = (32'(table_size_q) > TABLE_DEPTH) ? POS_W'(TABLE_DEPTH) : table_size_q;

	// Probe point: exact search rounds the middle of [lo, hi) down; the bisect
	// modes take the floor of the average of lo and hi.
	assign lo_hi_sum = {1'b0, lo_q} + {1'b0, hi_q};
	always_comb begin
		if (mode_q == MODE_EXACT) begin
			mid = lo_q + ((hi_q - lo_q - POS_W'(1)) >> 1);
		end else begin
			mid = POS_W'(lo_hi_sum >> 1);
		end
	end

	// One set of comparators, shared by all compare states, works on the key read back from memory.
	assign mem_lt_key = (rd_data_q < key_q);
	assign key_lt_mem = (key_q < rd_data_q);
	assign mem_eq_key = (rd_data_q == key_q);

	// Window update after a middle probe.
	always_comb begin
		lo_next = lo_q;
		hi_next = hi_q;
		case (mode_q)
			MODE_BISECT_ALT: begin
				if (mem_lt_key) begin
					lo_next = mid;
				end else begin
					hi_next = mid;
				end
			end
			default: begin
				if (mem_lt_key) begin
					lo_next = mid + POS_W'(1);
				end else begin
					hi_next = mid;
				end
			end
		endcase
	end

	// Loop condition on the updated window. The alternative bisect stops when
	// the window is down to two neighbors.
	always_comb begin
		if (mode_q == MODE_BISECT_ALT) begin
			loop_go = ((hi_next - lo_next) > POS_W'(1));
		end else begin
			loop_go = (lo_next < hi_next);
		end
	end

	always_comb begin
		case (state_q)
			S_RD_FIRST: rd_addr = '0;
			S_RD_LAST:  rd_addr = AW'(hi_q);
			default:    rd_addr = AW'(mid);
		endcase
	end

	assign wr_en = accept && (item.mode == MODE_WRITE) && (32'(item.entry_index) < TABLE_DEPTH);

	// Key memory: one write port, one read port, read data registered.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_mem[AW'(item.entry_index)] <= item.key;
		end
		rd_data_q <= key_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_size_q <= '0;
		end else if (cfg_we) begin
			table_size_q <= cfg_data;
		end
	end

	// Sequencer and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept && (item.mode != MODE_WRITE)) begin
						if (eff_size == '0) begin
							result_valid_q <= 1'b1;
						end else if (item.mode == MODE_EXACT) begin
							state_q <= S_RD_MID;
						end else begin
							state_q <= S_RD_FIRST;
						end
					end
				end
				S_RD_FIRST: state_q <= S_CMP_FIRST;
				S_CMP_FIRST: begin
					if (key_lt_mem) begin
						result_valid_q <= 1'b1;
						state_q        <= S_IDLE;
					end else begin
						state_q <= S_RD_LAST;
					end
				end
				S_RD_LAST: state_q <= S_CMP_LAST;
				S_CMP_LAST: begin
					if (!key_lt_mem || (mode_q == MODE_BISECT_ALT && hi_q <= POS_W'(1))) begin
						result_valid_q <= 1'b1;
						state_q        <= S_IDLE;
					end else begin
						state_q <= S_RD_MID;
					end
				end
				S_RD_MID: state_q <= S_CMP_MID;
				S_CMP_MID: begin
					if ((mode_q == MODE_EXACT && mem_eq_key) || !loop_go) begin
						result_valid_q <= 1'b1;
						state_q        <= S_IDLE;
					end else begin
						state_q <= S_RD_MID;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers: query, window and result payload.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					mode_q      <= item.mode;
					key_q       <= item.key;
					lo_q        <= '0;
					res_pos_q   <= '0;
					res_found_q <= 1'b0;
					res_empty_q <= (eff_size == '0);
					if (item.mode == MODE_EXACT) begin
						hi_q <= eff_size;
					end else begin
						hi_q <= eff_size - POS_W'(1);
					end
				end
			end
			S_CMP_FIRST: begin
				res_pos_q <= '0;
			end
			S_CMP_LAST: begin
				res_pos_q <= hi_q;
			end
			S_CMP_MID: begin
				lo_q <= lo_next;
				hi_q <= hi_next;
				if (mode_q == MODE_EXACT && mem_eq_key) begin
					res_pos_q   <= mid;
					res_found_q <= 1'b1;
				end else if (mode_q == MODE_BISECT_ALT) begin
					res_pos_q <= hi_next;
				end else begin
					res_pos_q <= lo_next;
				end
			end
			default: begin
			end
		endcase
	end

	assign result_valid       = result_valid_q;
	assign result.position    = res_pos_q;
	assign result.found       = res_found_q;
	assign result.empty_table = res_empty_q;

	// A result is only ever shown once the sequencer is back in idle.
	a_result_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !busy)
		else $error("result shown while a search is still running");

	// An empty-table result carries no position and no hit.
	a_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.empty_table) |-> (result.position == '0 && !result.found))
		else $error("empty table result has a nonzero position or a hit");

	// A hit always points inside the table.
	a_found_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.found) |-> (32'(result.position) < TABLE_DEPTH))
		else $error("hit position beyond the table");

	// A write transaction never produces a result.
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.mode == MODE_WRITE) |=> !result_valid)
		else $error("write transaction produced a result");

endmodule
